// File: rtl/ndpl_pkg.sv
// Shared types and constants for the nearest-neighbor downscaler with palette lookup.
package ndpl_pkg;

	localparam int PIX_W   = 8;
	localparam int COLOR_W = 16;
	localparam int COORD_W = 7;

	localparam logic OP_PIXEL     = 1'b0;
	localparam logic OP_PAL_WRITE = 1'b1;

	typedef struct packed {
		logic               op;
		logic               frame_start;
		logic [PIX_W-1:0]   src_pixel;
		logic [PIX_W-1:0]   palette_addr;
		logic [COLOR_W-1:0] palette_color;
	} in_t;

	typedef struct packed {
		logic [COLOR_W-1:0] rgb565;
		logic [COORD_W-1:0] dest_x;
		logic [COORD_W-1:0] dest_y;
		logic               band_end;
		logic               frame_end;
	} out_t;

	typedef struct packed {
		logic               keep;
		logic [COORD_W-1:0] dest_x;
		logic [COORD_W-1:0] dest_y;
		logic               band_end;
		logic               frame_end;
	} scan_t;

endpackage

// File: rtl/ndpl_scan.sv
// Source and destination position counters with stepping accumulators that select kept pixels.
module ndpl_scan import ndpl_pkg::*; #(
	parameter int SRC_WIDTH  = 320,
	parameter int SRC_HEIGHT = 240,
	parameter int DST_WIDTH  = 128,
	parameter int DST_HEIGHT = 128,
	parameter int BAND_LINES = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  logic  frame_start,
	output scan_t scan
);

	localparam int SCW = $clog2(SRC_WIDTH);
	localparam int SRW = $clog2(SRC_HEIGHT + 1);
	localparam int DCW = $clog2(DST_WIDTH + 1);
	localparam int DRW = $clog2(DST_HEIGHT + 1);
	localparam int NCW = $clog2(SRC_WIDTH + 1);
	localparam int CRW = $clog2(DST_WIDTH + 1);
	localparam int RRW = $clog2(DST_HEIGHT + 1);
	localparam int BW  = $clog2(BAND_LINES + 1);

	localparam int COL_QUOT = SRC_WIDTH / DST_WIDTH;
	localparam int COL_REM  = SRC_WIDTH % DST_WIDTH;
	localparam int ROW_QUOT = SRC_HEIGHT / DST_HEIGHT;
	localparam int ROW_REM  = SRC_HEIGHT % DST_HEIGHT;

	logic [SCW-1:0] src_col_q, c_src_col, n_src_col;
	logic [SRW-1:0] src_row_q, c_src_row, n_src_row;
	logic [DCW-1:0] dst_col_q, c_dst_col, n_dst_col;
	logic [DRW-1:0] dst_row_q, c_dst_row, n_dst_row;
	logic [NCW-1:0] nk_col_q, c_nk_col, n_nk_col;
	logic [SRW-1:0] nk_row_q, c_nk_row, n_nk_row;
	logic [CRW-1:0] col_rem_q, c_col_rem, n_col_rem;
	logic [RRW-1:0] row_rem_q, c_row_rem, n_row_rem;
	logic [BW-1:0]  band_q, c_band, n_band;

	logic           row_kept, keep, last_col, last_row;
	logic [CRW:0]   col_sum;
	logic [RRW:0]   row_sum;

	always_comb begin
		c_src_col = frame_start ? '0 : src_col_q;
		c_src_row = frame_start ? '0 : src_row_q;
		c_dst_col = frame_start ? '0 : dst_col_q;
		c_dst_row = frame_start ? '0 : dst_row_q;
		c_nk_col  = frame_start ? '0 : nk_col_q;
		c_nk_row  = frame_start ? '0 : nk_row_q;
		c_col_rem = frame_start ? '0 : col_rem_q;
		c_row_rem = frame_start ? '0 : row_rem_q;
		c_band    = frame_start ? '0 : band_q;
	end

	assign row_kept = (c_src_row == c_nk_row) && (c_dst_row < DRW'(DST_HEIGHT));
	assign keep     = row_kept && (NCW'(c_src_col) == c_nk_col) && (c_dst_col < DCW'(DST_WIDTH));
	assign last_col = (c_dst_col == DCW'(DST_WIDTH - 1));
	assign last_row = (c_dst_row == DRW'(DST_HEIGHT - 1));

	assign scan.keep      = keep;
	assign scan.dest_x    = COORD_W'(c_dst_col);
	assign scan.dest_y    = COORD_W'(c_dst_row);
	assign scan.band_end  = last_col && (last_row || (c_band == BW'(BAND_LINES - 1)));
	assign scan.frame_end = last_col && last_row;

	assign col_sum = {1'b0, c_col_rem} + (CRW + 1)'(COL_REM);
	assign row_sum = {1'b0, c_row_rem} + (RRW + 1)'(ROW_REM);

	always_comb begin
		n_src_col = c_src_col;
		n_src_row = c_src_row;
		n_dst_col = c_dst_col;
		n_dst_row = c_dst_row;
		n_nk_col  = c_nk_col;
		n_nk_row  = c_nk_row;
		n_col_rem = c_col_rem;
		n_row_rem = c_row_rem;
		n_band    = c_band;
		if (keep) begin
			n_dst_col = c_dst_col + DCW'(1);
			if (col_sum >= (CRW + 1)'(DST_WIDTH)) begin
				n_col_rem = CRW'(col_sum - (CRW + 1)'(DST_WIDTH));
				n_nk_col  = c_nk_col + NCW'(COL_QUOT) + NCW'(1);
			end else begin
				n_col_rem = CRW'(col_sum);
				n_nk_col  = c_nk_col + NCW'(COL_QUOT);
			end
		end
		if (c_src_col == SCW'(SRC_WIDTH - 1)) begin
			n_src_col = '0;
			n_dst_col = '0;
			n_nk_col  = '0;
			n_col_rem = '0;
			if (row_kept) begin
				n_dst_row = c_dst_row + DRW'(1);
				n_band    = (c_band == BW'(BAND_LINES - 1)) ? '0 : c_band + BW'(1);
				if (row_sum >= (RRW + 1)'(DST_HEIGHT)) begin
					n_row_rem = RRW'(row_sum - (RRW + 1)'(DST_HEIGHT));
					n_nk_row  = c_nk_row + SRW'(ROW_QUOT) + SRW'(1);
				end else begin
					n_row_rem = RRW'(row_sum);
					n_nk_row  = c_nk_row + SRW'(ROW_QUOT);
				end
			end
			n_src_row = c_src_row + SRW'(1);
			if (n_src_row == SRW'(SRC_HEIGHT)) begin
				n_src_row = '0;
				n_dst_row = '0;
				n_nk_row  = '0;
				n_row_rem = '0;
				n_band    = '0;
			end
		end else begin
			n_src_col = c_src_col + SCW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			dst_col_q <= '0;
			dst_row_q <= '0;
			nk_col_q  <= '0;
			nk_row_q  <= '0;
			col_rem_q <= '0;
			row_rem_q <= '0;
			band_q    <= '0;
		end else if (step) begin
			src_col_q <= n_src_col;
			src_row_q <= n_src_row;
			dst_col_q <= n_dst_col;
			dst_row_q <= n_dst_row;
			nk_col_q  <= n_nk_col;
			nk_row_q  <= n_nk_row;
			col_rem_q <= n_col_rem;
			row_rem_q <= n_row_rem;
			band_q    <= n_band;
		end
	end

endmodule

// File: rtl/nearest_downscale_palette_lookup.sv
// Top level of the nearest-neighbor downscaler: position selection, palette memory, output stage.
//
//   channel  | direction | payload | handshake
//   in       | sink      | in_t    | in_valid / in_ready
//   out      | source    | out_t   | out_valid / out_ready
//
// One beat is accepted per cycle while out is not stalled; a kept pixel passes through
// the registered palette read and then the output register before it shows on out.
// Reset clears all counters and both valid flags; palette contents are undefined until written.
// When out stalls, one further kept pixel is held in the read stage before in_ready drops.
module nearest_downscale_palette_lookup import ndpl_pkg::*; #(
	parameter int SRC_WIDTH  = 320,
	parameter int SRC_HEIGHT = 240,
	parameter int DST_WIDTH  = 128,
	parameter int DST_HEIGHT = 128,
	parameter int BAND_LINES = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic               accept, pix_acc, pal_wr, adv_s1;
	logic               valid_s1, out_valid_q;
	logic [COLOR_W-1:0] pal_mem [2**PIX_W];
	logic [COLOR_W-1:0] color_s1;
	scan_t              scan, scan_s1;
	out_t               out_data_q;

	assign accept  = in_valid && in_ready;
	assign pix_acc = accept && (in_data.op == OP_PIXEL);
	assign pal_wr  = accept && (in_data.op == OP_PAL_WRITE);
	assign adv_s1  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	ndpl_scan #(
		.SRC_WIDTH (SRC_WIDTH),
		.SRC_HEIGHT(SRC_HEIGHT),
		.DST_WIDTH (DST_WIDTH),
		.DST_HEIGHT(DST_HEIGHT),
		.BAND_LINES(BAND_LINES)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (pix_acc),
		.frame_start(in_data.frame_start),
		.scan       (scan)
	);

	always_ff @(posedge clk) begin
		if (pal_wr) begin
			pal_mem[in_data.palette_addr] <= in_data.palette_color;
		end
		if (pix_acc) begin
			color_s1 <= pal_mem[in_data.src_pixel];
			scan_s1  <= scan;
		end
		if (adv_s1) begin
			out_data_q.rgb565    <= color_s1;
			out_data_q.dest_x    <= scan_s1.dest_x;
			out_data_q.dest_y    <= scan_s1.dest_y;
			out_data_q.band_end  <= scan_s1.band_end;
			out_data_q.frame_end <= scan_s1.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pix_acc && scan.keep) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: rtl/ndpl_checker.sv
// Port-level checker for the downscaler and its bind to the top level.
module ndpl_checker import ndpl_pkg::*; #(
	parameter int DST_WIDTH  = 128,
	parameter int DST_HEIGHT = 128
) (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// A result that is not taken must hold.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled out beat changed");

	// The input side only backs up behind a stalled output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low without output stall");

	// The last pixel of a frame also closes a band.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_end |-> out_data.band_end)
		else $error("frame_end without band_end");

	// The last pixel of a frame sits in the last destination column and row.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_end |->
			out_data.dest_x == COORD_W'(DST_WIDTH - 1) &&
			out_data.dest_y == COORD_W'(DST_HEIGHT - 1))
		else $error("frame_end at wrong position");

endmodule

bind nearest_downscale_palette_lookup ndpl_checker #(
	.DST_WIDTH (DST_WIDTH),
	.DST_HEIGHT(DST_HEIGHT)
) u_ndpl_checker (.*);

// File: dv/nearest_downscale_palette_lookup_tb.sv
// Testbench for the nearest-neighbor downscaler with palette lookup, checked against a predictor.
module nearest_downscale_palette_lookup_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ndpl_pkg::*;

	localparam int SRC_W = 320;
	localparam int SRC_H = 240;
	localparam int DST_W = 128;
	localparam int DST_H = 128;
	localparam int BAND = 32;
	localparam int COL_QUOT = SRC_W / DST_W;
	localparam int COL_REM = SRC_W % DST_W;
	localparam int ROW_QUOT = SRC_H / DST_H;
	localparam int ROW_REM = SRC_H % DST_H;
	localparam int WATCHDOG_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	bit in_idle_en = 1'b1;
	bit out_idle_en = 1'b1;
	int mismatches = 0;
	int stall_cycles = 0;

	logic [COLOR_W-1:0] pal_model [256];
	bit pal_loaded [256];
	logic [PIX_W-1:0] loaded_idx [$];
	logic [8:0] src_col_m, next_col_m, col_rem_m;
	logic [7:0] src_row_m, dst_col_m, dst_row_m, next_row_m, row_rem_m;
	out_t pending_pixels [$];

	nearest_downscale_palette_lookup #(
		.SRC_WIDTH(SRC_W),
		.SRC_HEIGHT(SRC_H),
		.DST_WIDTH(DST_W),
		.DST_HEIGHT(DST_H),
		.BAND_LINES(BAND)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= !out_idle_en || ($urandom_range(99) >= 32);
	end

	task automatic clear_scan_state();
		src_col_m = '0;
		src_row_m = '0;
		dst_col_m = '0;
		dst_row_m = '0;
		next_col_m = '0;
		next_row_m = '0;
		col_rem_m = '0;
		row_rem_m = '0;
	endtask

	task automatic scale_and_lookup(input in_t b);
		logic row_hit;
		logic last_col;
		logic last_row;
		out_t px;
		if (b.op == OP_PAL_WRITE) begin
			pal_model[b.palette_addr] = b.palette_color;
			return;
		end
		if (b.frame_start) begin
			clear_scan_state();
		end
		row_hit = (src_row_m == next_row_m) && (dst_row_m < DST_H);
		if (row_hit && src_col_m == next_col_m && dst_col_m < DST_W) begin
			last_col = (dst_col_m == DST_W - 1);
			last_row = (dst_row_m == DST_H - 1);
			px.rgb565 = pal_model[b.src_pixel];
			px.dest_x = dst_col_m[COORD_W-1:0];
			px.dest_y = dst_row_m[COORD_W-1:0];
			px.band_end = last_col && (last_row || ((dst_row_m + 1) % BAND == 0));
			px.frame_end = last_col && last_row;
			pending_pixels.push_back(px);
			dst_col_m++;
			next_col_m += 9'(COL_QUOT);
			col_rem_m += 9'(COL_REM);
			if (col_rem_m >= DST_W) begin
				col_rem_m -= 9'(DST_W);
				next_col_m++;
			end
		end
		if (src_col_m >= SRC_W - 1) begin
			src_col_m = '0;
			dst_col_m = '0;
			next_col_m = '0;
			col_rem_m = '0;
			if (row_hit) begin
				dst_row_m++;
				next_row_m += 8'(ROW_QUOT);
				row_rem_m += 8'(ROW_REM);
				if (row_rem_m >= DST_H) begin
					row_rem_m -= 8'(DST_H);
					next_row_m++;
				end
			end
			src_row_m++;
			if (src_row_m >= SRC_H) begin
				clear_scan_state();
			end
		end else begin
			src_col_m++;
		end
	endtask

	always @(posedge clk) begin : output_check
		out_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				scale_and_lookup(in_data);
			end
			if (out_valid && out_ready) begin
				if (pending_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unexpected pixel rgb=%h x=%0d y=%0d band=%b end=%b",
							$realtime, out_data.rgb565, out_data.dest_x, out_data.dest_y,
							out_data.band_end, out_data.frame_end);
					end
				end else begin
					want = pending_pixels.pop_front();
					if (out_data.rgb565 !== want.rgb565 || out_data.dest_x !== want.dest_x ||
						out_data.dest_y !== want.dest_y || out_data.band_end !== want.band_end ||
						out_data.frame_end !== want.frame_end) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: expected rgb=%h x=%0d y=%0d band=%b end=%b",
								$realtime, want.rgb565, want.dest_x, want.dest_y,
								want.band_end, want.frame_end);
							$display("%0t:   actual rgb=%h x=%0d y=%0d band=%b end=%b",
								$realtime, out_data.rgb565, out_data.dest_x, out_data.dest_y,
								out_data.band_end, out_data.frame_end);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic in_t pixel_beat(input logic fs, input logic [PIX_W-1:0] idx);
		in_t b;
		b.op = OP_PIXEL;
		b.frame_start = fs;
		b.src_pixel = idx;
		b.palette_addr = PIX_W'($urandom);
		b.palette_color = COLOR_W'($urandom);
		return b;
	endfunction

	function automatic in_t write_beat(input logic [PIX_W-1:0] addr,
		input logic [COLOR_W-1:0] color);
		in_t b;
		b.op = OP_PAL_WRITE;
		b.frame_start = 1'($urandom);
		b.src_pixel = PIX_W'($urandom);
		b.palette_addr = addr;
		b.palette_color = color;
		if (!pal_loaded[addr]) begin
			pal_loaded[addr] = 1'b1;
			loaded_idx.push_back(addr);
		end
		return b;
	endfunction

	function automatic logic [PIX_W-1:0] pick_index();
		return loaded_idx[$urandom_range(loaded_idx.size() - 1)];
	endfunction

	task automatic send_beat(input in_t b);
		@(negedge clk);
		while (in_idle_en && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic test_palette_and_restart();
		send_beat(write_beat(8'h00, 16'h0000));
		send_beat(write_beat(8'hFF, 16'hFFFF));
		send_beat(write_beat(8'h55, 16'hAAAA));
		send_beat(write_beat(8'hAA, 16'h5555));
		send_beat(pixel_beat(1'b1, 8'hFF));
		send_beat(pixel_beat(1'b0, 8'h00));
		send_beat(pixel_beat(1'b0, 8'h55));
		send_beat(pixel_beat(1'b0, 8'hAA));
		send_beat(pixel_beat(1'b0, 8'h00));
		// The entry is rewritten right before a kept pixel reads it.
		send_beat(write_beat(8'h55, 16'h1234));
		send_beat(pixel_beat(1'b0, 8'h55));
		send_beat(pixel_beat(1'b0, 8'hFF));
		send_beat(pixel_beat(1'b1, 8'h00));
		send_beat(pixel_beat(1'b0, 8'hFF));
		send_beat(write_beat(8'hAA, 16'h8001));
		send_beat(pixel_beat(1'b0, 8'hAA));
		send_beat(pixel_beat(1'b1, 8'h55));
		drain();
	endtask

	task automatic test_random_stream();
		int r;
		logic [PIX_W-1:0] a;
		send_beat(pixel_beat(1'b1, pick_index()));
		for (int i = 0; i < 400; i++) begin
			if (i == 200) begin
				drain();
			end
			r = $urandom_range(99);
			if (r < 8) begin
				send_beat(write_beat(PIX_W'($urandom), COLOR_W'($urandom)));
			end else if (r < 11) begin
				a = PIX_W'($urandom);
				send_beat(write_beat(a, COLOR_W'($urandom)));
				send_beat(pixel_beat(1'b0, a));
			end else begin
				send_beat(pixel_beat($urandom_range(299) == 0, pick_index()));
			end
		end
		drain();
	endtask

	task automatic test_burst();
		in_idle_en = 1'b0;
		out_idle_en = 1'b0;
		send_beat(pixel_beat(1'b1, pick_index()));
		for (int i = 1; i < 200; i++) begin
			if (i == 100) begin
				in_idle_en = 1'b1;
				out_idle_en = 1'b1;
			end
			if ($urandom_range(49) == 0) begin
				send_beat(write_beat(PIX_W'($urandom), COLOR_W'($urandom)));
			end
			send_beat(pixel_beat(1'b0, pick_index()));
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		clear_scan_state();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_palette_and_restart();
		test_random_stream();
		test_burst();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
